// ----- design/jsu_pkg.sv -----
package jsu_pkg;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_BODY    = 4'd1,
      PH_ESC     = 4'd2,
      PH_HEX_HI  = 4'd3,
      PH_WANT_BS = 4'd4,
      PH_WANT_U  = 4'd5,
      PH_HEX_LO  = 4'd6,
      PH_DONE    = 4'd7,
      PH_ERROR   = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // code 0 doubles as the idle value on data and close items
   typedef logic [3:0] err_type;

   localparam err_type ERR_NONE          = 4'd0;
   localparam err_type ERR_NO_OPEN_QUOTE = 4'd0;
   localparam err_type ERR_UNTERM_STRING = 4'd1;
   localparam err_type ERR_UNTERM_ESCAPE = 4'd2;
   localparam err_type ERR_BAD_ESCAPE    = 4'd3;
   localparam err_type ERR_RAW_CONTROL   = 4'd4;
   localparam err_type ERR_SHORT_UNICODE = 4'd5;
   localparam err_type ERR_BAD_HEX       = 4'd6;
   localparam err_type ERR_LONE_LOW      = 4'd7;
   localparam err_type ERR_NO_LOW_ESCAPE = 4'd8;
   localparam err_type ERR_SHORT_LOW     = 4'd9;
   localparam err_type ERR_BAD_LOW       = 4'd10;

   localparam int unsigned MaxResults = 4;

   localparam logic [7:0] ChQuote     = 8'h22;
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChSlash     = 8'h2F;
   localparam logic [7:0] ChLowerB    = 8'h62;
   localparam logic [7:0] ChLowerF    = 8'h66;
   localparam logic [7:0] ChLowerN    = 8'h6E;
   localparam logic [7:0] ChLowerR    = 8'h72;
   localparam logic [7:0] ChLowerT    = 8'h74;
   localparam logic [7:0] ChLowerU    = 8'h75;
   localparam logic [7:0] ChSpace     = 8'h20;

   localparam logic [15:0] SurrFirst    = 16'hD800;
   localparam logic [15:0] SurrHighLast = 16'hDBFF;
   localparam logic [15:0] SurrLowFirst = 16'hDC00;
   localparam logic [15:0] SurrLast     = 16'hDFFF;
   localparam logic [20:0] SuppBase     = 21'h10000;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      err_type    code;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   typedef struct packed {
      logic [2:0]      n;
      logic [3:0][7:0] bytes;
   } utf8_type;

   function automatic result_type mk_result(kind_type kind, logic [7:0] data,
                                            err_type code);
      result_type r;
      r.kind = kind;
      r.data = data;
      r.code = code;
      return r;
   endfunction

   function automatic hex_type hex_value(logic [7:0] b);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.val = 4'(b - 8'h61 + 8'd10);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.val = 4'(b - 8'h41 + 8'd10);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic utf8_type utf8_encode(logic [20:0] cp);
      utf8_type u;
      u.n     = 3'd0;
      u.bytes = '0;
      if (cp <= 21'h7F) begin
         u.n        = 3'd1;
         u.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         u.n        = 3'd2;
         u.bytes[0] = {3'b110, cp[10:6]};
         u.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         u.n        = 3'd3;
         u.bytes[0] = {4'b1110, cp[15:12]};
         u.bytes[1] = {2'b10, cp[11:6]};
         u.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         u.n        = 3'd4;
         u.bytes[0] = {5'b11110, cp[20:18]};
         u.bytes[1] = {2'b10, cp[17:12]};
         u.bytes[2] = {2'b10, cp[11:6]};
         u.bytes[3] = {2'b10, cp[5:0]};
      end
      return u;
   endfunction

endpackage

// ----- design/json_string_unescape_utf8_core.sv -----
// JSON string literal unescaper: feed the raw bytes of one literal, opening quote
// first, one item per cycle. Decoded UTF-8 bytes come out one per cycle while
// rsp_stall is low, followed by a close marker at the closing quote; any error
// gives a single error item and the block then drops everything until an item
// with restart set. An input item is decoded in the cycle it is accepted and its
// results (up to four, for a surrogate pair) land in a small result buffer; the
// next item is taken as soon as that buffer holds at most one result that leaves
// in the same cycle. So the block takes one input byte per cycle while rsp_stall
// is low and each item yields at most one result; longer runs stall the input.
module json_string_unescape_utf8_core
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_restart,
   input  logic       req_input_ends,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [3:0] rsp_error_code,
   output logic       rsp_last_of_run
);

   phase_type  phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [9:0]  hs_ff, hs_in;

   result_type  buf_ff [MaxResults];
   logic [2:0]  num_ff;

   result_type  res [MaxResults];
   logic [2:0]  nres;

   logic        req_accept;
   logic        rsp_accept;
   hex_type     hv;
   logic [15:0] acc_next;
   logic [20:0] cp_pair;
   utf8_type    enc;

   assign rsp_valid  = (num_ff != 3'd0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = !((num_ff == 3'd0) || ((num_ff == 3'd1) && rsp_accept));
   assign req_accept = req_valid && !req_stall;

   assign hv       = hex_value(req_in_byte);
   assign acc_next = {acc_ff[11:0], hv.val};
   assign cp_pair  = {1'b0, hs_ff, acc_next[9:0]} + SuppBase;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      hs_in    = hs_ff;
      nres     = 3'd0;
      enc      = utf8_encode({5'd0, acc_next});
      for (int i = 0; i < MaxResults; i++) begin
         res[i] = mk_result(KIND_DATA, 8'd0, ERR_NONE);
      end

      if (req_restart) begin
         phase_in = PH_IDLE;
         acc_in   = '0;
         cnt_in   = '0;
         hs_in    = '0;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (req_input_ends || req_in_byte != ChQuote) begin
                  phase_in = PH_ERROR;
                  nres     = 3'd1;
                  res[0]   = mk_result(KIND_ERROR, 8'd0, ERR_NO_OPEN_QUOTE);
               end else begin
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               priority if (req_input_ends) begin
                  phase_in = PH_ERROR;
                  nres     = 3'd1;
                  res[0]   = mk_result(KIND_ERROR, 8'd0, ERR_UNTERM_STRING);
               end else if (req_in_byte == ChQuote) begin
                  phase_in = PH_DONE;
                  nres     = 3'd1;
                  res[0]   = mk_result(KIND_CLOSE, 8'd0, ERR_NONE);
               end else if (req_in_byte == ChBackslash) begin
                  phase_in = PH_ESC;
               end else if (req_in_byte < ChSpace) begin
                  phase_in = PH_ERROR;
                  nres     = 3'd1;
                  res[0]   = mk_result(KIND_ERROR, 8'd0, ERR_RAW_CONTROL);
               end else begin
                  nres   = 3'd1;
                  res[0] = mk_result(KIND_DATA, req_in_byte, ERR_NONE);
               end
            end
            PH_ESC: begin
               phase_in = PH_BODY;
               nres     = 3'd1;
               if (req_input_ends) begin
                  phase_in = PH_ERROR;
                  res[0]   = mk_result(KIND_ERROR, 8'd0, ERR_UNTERM_ESCAPE);
               end else begin
                  unique case (req_in_byte)
                     ChQuote, ChBackslash, ChSlash:
                        res[0] = mk_result(KIND_DATA, req_in_byte, ERR_NONE);
                     ChLowerB: res[0] = mk_result(KIND_DATA, 8'h08, ERR_NONE);
                     ChLowerF: res[0] = mk_result(KIND_DATA, 8'h0C, ERR_NONE);
                     ChLowerN: res[0] = mk_result(KIND_DATA, 8'h0A, ERR_NONE);
                     ChLowerR: res[0] = mk_result(KIND_DATA, 8'h0D, ERR_NONE);
                     ChLowerT: res[0] = mk_result(KIND_DATA, 8'h09, ERR_NONE);
                     ChLowerU: begin
                        nres     = 3'd0;
                        acc_in   = '0;
                        cnt_in   = '0;
                        phase_in = PH_HEX_HI;
                     end
                     default: begin
                        phase_in = PH_ERROR;
                        res[0]   = mk_result(KIND_ERROR, 8'd0, ERR_BAD_ESCAPE);
                     end
                  endcase
               end
            end
            PH_HEX_HI, PH_HEX_LO: begin
               priority if (req_input_ends) begin
                  phase_in = PH_ERROR;
                  nres     = 3'd1;
                  res[0]   = mk_result(KIND_ERROR, 8'd0,
                                       (phase_ff == PH_HEX_HI) ? ERR_SHORT_UNICODE
                                                               : ERR_SHORT_LOW);
               end else if (!hv.ok) begin
                  phase_in = PH_ERROR;
                  nres     = 3'd1;
                  res[0]   = mk_result(KIND_ERROR, 8'd0, ERR_BAD_HEX);
               end else if (cnt_ff != 2'd3) begin
                  acc_in = acc_next;
                  cnt_in = cnt_ff + 2'd1;
               end else begin
                  acc_in = acc_next;
                  cnt_in = '0;
                  if (phase_ff == PH_HEX_HI) begin
                     priority if (acc_next < SurrFirst || acc_next > SurrLast) begin
                        phase_in = PH_BODY;
                     end else if (acc_next > SurrHighLast) begin
                        phase_in = PH_ERROR;
                        nres     = 3'd1;
                        res[0]   = mk_result(KIND_ERROR, 8'd0, ERR_LONE_LOW);
                     end else begin
                        hs_in    = acc_next[9:0];
                        phase_in = PH_WANT_BS;
                     end
                  end else begin
                     if (acc_next < SurrLowFirst || acc_next > SurrLast) begin
                        phase_in = PH_ERROR;
                        nres     = 3'd1;
                        res[0]   = mk_result(KIND_ERROR, 8'd0, ERR_BAD_LOW);
                     end else begin
                        enc      = utf8_encode(cp_pair);
                        phase_in = PH_BODY;
                     end
                  end
                  // emit the encoded code point when the phase went back to body
                  if (phase_in == PH_BODY) begin
                     nres = enc.n;
                     for (int i = 0; i < MaxResults; i++) begin
                        res[i] = mk_result(KIND_DATA, enc.bytes[i], ERR_NONE);
                     end
                  end
               end
            end
            PH_WANT_BS: begin
               if (req_input_ends || req_in_byte != ChBackslash) begin
                  phase_in = PH_ERROR;
                  nres     = 3'd1;
                  res[0]   = mk_result(KIND_ERROR, 8'd0, ERR_NO_LOW_ESCAPE);
               end else begin
                  phase_in = PH_WANT_U;
               end
            end
            PH_WANT_U: begin
               if (req_input_ends || req_in_byte != ChLowerU) begin
                  phase_in = PH_ERROR;
                  nres     = 3'd1;
                  res[0]   = mk_result(KIND_ERROR, 8'd0, ERR_NO_LOW_ESCAPE);
               end else begin
                  acc_in   = '0;
                  cnt_in   = '0;
                  phase_in = PH_HEX_LO;
               end
            end
            default: begin
               // closed or failed: drop everything until restart
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         hs_ff    <= '0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         hs_ff    <= hs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
      end else if (req_accept) begin
         num_ff <= nres;
      end else if (rsp_accept) begin
         num_ff <= num_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int i = 0; i < MaxResults; i++) begin
            buf_ff[i] <= res[i];
         end
      end else if (rsp_accept) begin
         // advance to the next result of this run
         for (int i = 0; i < MaxResults - 1; i++) begin
            buf_ff[i] <= buf_ff[i + 1];
         end
      end
   end

   assign rsp_kind        = buf_ff[0].kind;
   assign rsp_data_byte   = buf_ff[0].data;
   assign rsp_error_code  = buf_ff[0].code;
   assign rsp_last_of_run = (num_ff == 3'd1);

   a_num_range : assert property (@(posedge clock) disable iff (reset)
      num_ff <= 3'd4)
      else $error("result buffer count out of range");

   a_single_marker : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_DATA) |-> rsp_last_of_run)
      else $error("close or error item is not alone in its run");

   a_code_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_ERROR) |-> (rsp_error_code == 4'd0))
      else $error("nonzero error code on a non-error item");

   a_error_sticky : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR && !(req_accept && req_restart)) |=> (phase_ff == PH_ERROR))
      else $error("left the error phase without restart");

endmodule
